// ===== rtl/sst_pkg.sv =====
// Shared types, widths and codes of the scoped symbol table.
package sst_pkg;

   localparam int LOCAL_DEPTH  = 64;
   localparam int GLOBAL_DEPTH = 64;

   localparam int KEY_W   = 32;
   localparam int VALUE_W = 32;
   localparam int MODE_W  = 3;
   localparam int STAT_W  = 3;
   localparam int KIND_W  = 2;

   localparam int LCNT_W = $clog2(LOCAL_DEPTH + 1);
   localparam int LIDX_W = (LOCAL_DEPTH > 1) ? $clog2(LOCAL_DEPTH) : 1;
   localparam int GCNT_W = $clog2(GLOBAL_DEPTH + 1);
   localparam int GIDX_W = (GLOBAL_DEPTH > 1) ? $clog2(GLOBAL_DEPTH) : 1;

   localparam int REQ_BITS    = MODE_W + KEY_W + VALUE_W;
   localparam int REQ_TDATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS    = VALUE_W + STAT_W;
   localparam int RSP_TDATA_W = ((RSP_BITS + 7) / 8) * 8;

   typedef enum logic [MODE_W-1:0] {
      MODE_DECL_LOCAL  = 3'd0,
      MODE_DECL_GLOBAL = 3'd1,
      MODE_SET         = 3'd2,
      MODE_GET         = 3'd3,
      MODE_ENTER_BLOCK = 3'd4,
      MODE_LEAVE_BLOCK = 3'd5,
      MODE_ENTER_FUNC  = 3'd6,
      MODE_LEAVE_FUNC  = 3'd7
   } mode_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK         = 3'd0,
      ST_DECLARED   = 3'd1,
      ST_UNDECLARED = 3'd2,
      ST_FULL       = 3'd3,
      ST_NO_MARKER  = 3'd4
   } status_type;

   localparam logic [KIND_W-1:0] KIND_VAR   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_BLOCK = 2'd1;
   localparam logic [KIND_W-1:0] KIND_FUNC  = 2'd2;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
   } lent_type;

   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
   } gent_type;

endpackage

// ===== rtl/scoped_symbol_table.sv =====
// Each item is taken in S_IDLE and dispatched by mode; it then walks the local entries (up to
// LOCAL_DEPTH) and/or the global entries (up to GLOBAL_DEPTH) before S_FINISH hands the result on.
// One item at a time: no next item is taken until the last has left S_FINISH;
// a key comparator per memory checks one memory entry per cycle.
// A finished result sits in an output register, so the next item may be taken meanwhile.
// Reset clears the counts, sequencer and output valid; table contents are left as they are.
module scoped_symbol_table (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // mode [2:0], key [34:3], value [66:35], zero pad above
   input  logic [sst_pkg::REQ_TDATA_W-1:0]     req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // result_value [31:0], status [34:32], zero pad above
   output logic [sst_pkg::RSP_TDATA_W-1:0]     rsp_tdata
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DISPATCH,
      S_LSCAN,
      S_GSCAN,
      S_FINISH
   } state_type;

   state_type                           state_ff, state_in;
   sst_pkg::mode_type                   mode_ff, mode_in;
   logic [sst_pkg::KEY_W-1:0]           key_ff, key_in;
   logic [sst_pkg::VALUE_W-1:0]         val_ff, val_in;
   logic [sst_pkg::LCNT_W-1:0]          lcount_ff, lcount_in;
   logic [sst_pkg::GCNT_W-1:0]          gcount_ff, gcount_in;
   logic [sst_pkg::LIDX_W-1:0]          lcur_ff, lcur_in;
   logic [sst_pkg::GIDX_W-1:0]          gcur_ff, gcur_in;
   logic [sst_pkg::VALUE_W-1:0]         res_ff, res_in;
   sst_pkg::status_type                 st_ff, st_in;
   logic                                rsp_tvalid_ff, rsp_tvalid_in;
   logic [sst_pkg::VALUE_W-1:0]         rsp_value_ff, rsp_value_in;
   sst_pkg::status_type                 rsp_status_ff, rsp_status_in;

   sst_pkg::lent_type                   lmem [sst_pkg::LOCAL_DEPTH];
   sst_pkg::gent_type                   gmem [sst_pkg::GLOBAL_DEPTH];
   sst_pkg::lent_type                   lrdata_ff;
   sst_pkg::gent_type                   grdata_ff;

   logic                                lwe, gwe;
   logic [sst_pkg::LIDX_W-1:0]          lwaddr, lraddr;
   logic [sst_pkg::GIDX_W-1:0]          gwaddr, graddr;
   sst_pkg::lent_type                   lwdata;
   sst_pkg::gent_type                   gwdata;

   logic                                lscan_end, gscan_end;
   logic                                lfull, gfull, is_set;
   logic                                key_hit_l, key_hit_g;
   logic [sst_pkg::KIND_W-1:0]          leave_kind;
   logic [sst_pkg::LCNT_W-1:0]          ltop;
   logic [sst_pkg::GCNT_W-1:0]          gtop;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {{(sst_pkg::RSP_TDATA_W - sst_pkg::RSP_BITS){1'b0}},
                        rsp_status_ff, rsp_value_ff};

   assign lfull      = (lcount_ff == sst_pkg::LCNT_W'(sst_pkg::LOCAL_DEPTH));
   assign gfull      = (gcount_ff == sst_pkg::GCNT_W'(sst_pkg::GLOBAL_DEPTH));
   assign is_set     = (mode_ff == sst_pkg::MODE_SET);
   assign key_hit_l  = (lrdata_ff.kind == sst_pkg::KIND_VAR) && (lrdata_ff.key == key_ff);
   assign key_hit_g  = (grdata_ff.key == key_ff);
   assign leave_kind = (mode_ff == sst_pkg::MODE_LEAVE_BLOCK) ? sst_pkg::KIND_BLOCK
                                                              : sst_pkg::KIND_FUNC;
   assign ltop       = lcount_ff - sst_pkg::LCNT_W'(1);
   assign gtop       = gcount_ff - sst_pkg::GCNT_W'(1);

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      key_in        = key_ff;
      val_in        = val_ff;
      lcount_in     = lcount_ff;
      gcount_in     = gcount_ff;
      lcur_in       = lcur_ff;
      gcur_in       = gcur_ff;
      res_in        = res_ff;
      st_in         = st_ff;
      rsp_tvalid_in = rsp_tvalid_ff & ~rsp_tready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      lwe           = 1'b0;
      gwe           = 1'b0;
      lwaddr        = lcount_ff[sst_pkg::LIDX_W-1:0];
      gwaddr        = gcount_ff[sst_pkg::GIDX_W-1:0];
      lwdata        = '{kind: sst_pkg::KIND_VAR, key: key_ff, value: val_ff};
      gwdata        = '{key: key_ff, value: val_ff};
      lraddr        = lcur_ff;
      graddr        = gcur_ff;
      lscan_end     = 1'b0;
      gscan_end     = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               mode_in  = sst_pkg::mode_type'(req_tdata[sst_pkg::MODE_W-1:0]);
               key_in   = req_tdata[sst_pkg::MODE_W +: sst_pkg::KEY_W];
               val_in   = req_tdata[sst_pkg::MODE_W + sst_pkg::KEY_W +: sst_pkg::VALUE_W];
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            unique case (mode_ff)
               sst_pkg::MODE_DECL_GLOBAL: begin
                  if (gcount_ff == '0) begin
                     gscan_end = 1'b1;
                  end else begin
                     graddr   = gtop[sst_pkg::GIDX_W-1:0];
                     gcur_in  = gtop[sst_pkg::GIDX_W-1:0];
                     state_in = S_GSCAN;
                  end
               end
               sst_pkg::MODE_ENTER_BLOCK, sst_pkg::MODE_ENTER_FUNC: begin
                  res_in   = '0;
                  state_in = S_FINISH;
                  if (lfull) begin
                     st_in = sst_pkg::ST_FULL;
                  end else begin
                     st_in     = sst_pkg::ST_OK;
                     lwe       = 1'b1;
                     lwdata    = '{kind: (mode_ff == sst_pkg::MODE_ENTER_BLOCK) ?
                                         sst_pkg::KIND_BLOCK : sst_pkg::KIND_FUNC,
                                   key: '0, value: '0};
                     lcount_in = lcount_ff + sst_pkg::LCNT_W'(1);
                  end
               end
               sst_pkg::MODE_DECL_LOCAL, sst_pkg::MODE_SET, sst_pkg::MODE_GET,
               sst_pkg::MODE_LEAVE_BLOCK, sst_pkg::MODE_LEAVE_FUNC: begin
                  if (lcount_ff == '0) begin
                     lscan_end = 1'b1;
                  end else begin
                     lraddr   = ltop[sst_pkg::LIDX_W-1:0];
                     lcur_in  = ltop[sst_pkg::LIDX_W-1:0];
                     state_in = S_LSCAN;
                  end
               end
               default: ;
            endcase
         end
         S_LSCAN: begin
            // The read data holds the entry at lcur_ff; the next entry down is fetched meanwhile.
            lraddr  = lcur_ff - sst_pkg::LIDX_W'(1);
            lcur_in = lcur_ff - sst_pkg::LIDX_W'(1);
            priority case (mode_ff)
               sst_pkg::MODE_DECL_LOCAL: begin
                  if (lrdata_ff.kind != sst_pkg::KIND_VAR) begin
                     lscan_end = 1'b1;
                  end else if (key_hit_l) begin
                     res_in   = '0;
                     st_in    = sst_pkg::ST_DECLARED;
                     state_in = S_FINISH;
                  end else if (lcur_ff == '0) begin
                     lscan_end = 1'b1;
                  end
               end
               sst_pkg::MODE_SET, sst_pkg::MODE_GET: begin
                  if (lrdata_ff.kind == sst_pkg::KIND_FUNC) begin
                     lscan_end = 1'b1;
                  end else if (key_hit_l) begin
                     st_in    = sst_pkg::ST_OK;
                     state_in = S_FINISH;
                     if (is_set) begin
                        lwe    = 1'b1;
                        lwaddr = lcur_ff;
                        res_in = val_ff;
                     end else begin
                        res_in = lrdata_ff.value;
                     end
                  end else if (lcur_ff == '0) begin
                     lscan_end = 1'b1;
                  end
               end
               default: begin
                  if (lrdata_ff.kind == leave_kind) begin
                     lcount_in = sst_pkg::LCNT_W'(lcur_ff);
                     res_in    = '0;
                     st_in     = sst_pkg::ST_OK;
                     state_in  = S_FINISH;
                  end else if (lcur_ff == '0) begin
                     lscan_end = 1'b1;
                  end
               end
            endcase
         end
         S_GSCAN: begin
            graddr  = gcur_ff - sst_pkg::GIDX_W'(1);
            gcur_in = gcur_ff - sst_pkg::GIDX_W'(1);
            if (key_hit_g) begin
               state_in = S_FINISH;
               if (mode_ff == sst_pkg::MODE_DECL_GLOBAL) begin
                  res_in = '0;
                  st_in  = sst_pkg::ST_DECLARED;
               end else begin
                  st_in = sst_pkg::ST_OK;
                  if (is_set) begin
                     gwe    = 1'b1;
                     gwaddr = gcur_ff;
                     res_in = val_ff;
                  end else begin
                     res_in = grdata_ff.value;
                  end
               end
            end else if (gcur_ff == '0) begin
               gscan_end = 1'b1;
            end
         end
         S_FINISH: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_value_in  = res_ff;
               rsp_status_in = st_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // No hit among the locals in reach, or no matching marker for a leave.
      if (lscan_end) begin
         priority case (mode_ff)
            sst_pkg::MODE_DECL_LOCAL: begin
               state_in = S_FINISH;
               if (lfull) begin
                  res_in = '0;
                  st_in  = sst_pkg::ST_FULL;
               end else begin
                  lwe       = 1'b1;
                  lwaddr    = lcount_ff[sst_pkg::LIDX_W-1:0];
                  lcount_in = lcount_ff + sst_pkg::LCNT_W'(1);
                  res_in    = val_ff;
                  st_in     = sst_pkg::ST_OK;
               end
            end
            sst_pkg::MODE_SET, sst_pkg::MODE_GET: begin
               if (gcount_ff == '0) begin
                  gscan_end = 1'b1;
               end else begin
                  graddr   = gtop[sst_pkg::GIDX_W-1:0];
                  gcur_in  = gtop[sst_pkg::GIDX_W-1:0];
                  state_in = S_GSCAN;
               end
            end
            default: begin
               lcount_in = '0;
               res_in    = '0;
               st_in     = sst_pkg::ST_NO_MARKER;
               state_in  = S_FINISH;
            end
         endcase
      end

      // No hit among the globals either.
      if (gscan_end) begin
         state_in = S_FINISH;
         if (mode_ff == sst_pkg::MODE_DECL_GLOBAL) begin
            if (gfull) begin
               res_in = '0;
               st_in  = sst_pkg::ST_FULL;
            end else begin
               gwe       = 1'b1;
               gwaddr    = gcount_ff[sst_pkg::GIDX_W-1:0];
               gcount_in = gcount_ff + sst_pkg::GCNT_W'(1);
               res_in    = val_ff;
               st_in     = sst_pkg::ST_OK;
            end
         end else begin
            res_in = '0;
            st_in  = sst_pkg::ST_UNDECLARED;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         lcount_ff     <= '0;
         gcount_ff     <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         lcount_ff     <= lcount_in;
         gcount_ff     <= gcount_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      mode_ff       <= mode_in;
      key_ff        <= key_in;
      val_ff        <= val_in;
      lcur_ff       <= lcur_in;
      gcur_ff       <= gcur_in;
      res_ff        <= res_in;
      st_ff         <= st_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_ff @(posedge clock) begin
      if (lwe) begin
         lmem[lwaddr] <= lwdata;
      end
      lrdata_ff <= lmem[lraddr];
   end

   always_ff @(posedge clock) begin
      if (gwe) begin
         gmem[gwaddr] <= gwdata;
      end
      grdata_ff <= gmem[graddr];
   end

endmodule

// ===== rtl/sst_checker.sv =====
// Port-level checks of the scoped symbol table, bound to the top level.
module sst_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [sst_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);

   // An accepted item keeps the block busy for at least the following cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken again straight after an item was accepted");

   // Error results, including failed scope operations, carry a zero value.
   a_error_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[sst_pkg::VALUE_W +: sst_pkg::STAT_W] != sst_pkg::ST_OK)
      |-> (rsp_tdata[sst_pkg::VALUE_W-1:0] == '0))
      else $error("error result with a nonzero value");

   // Leaving reset there is no stale result.
   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed or dropped");

endmodule

bind scoped_symbol_table sst_checker u_sst_checker (.*);

// ===== verif/testbench.sv =====
// Self-checking testbench for the scoped symbol table: random streams of scope operations.
module testbench;

   typedef struct {
      logic [sst_pkg::VALUE_W-1:0] value;
      logic [sst_pkg::STAT_W-1:0]  status;
   } sym_result_type;

   // Mirrors the local stack and the global table and holds the results still owed.
   class symtab_board;
      logic [sst_pkg::KEY_W-1:0]   lkeys  [sst_pkg::LOCAL_DEPTH];
      logic [sst_pkg::VALUE_W-1:0] lvals  [sst_pkg::LOCAL_DEPTH];
      logic [sst_pkg::KIND_W-1:0]  lkinds [sst_pkg::LOCAL_DEPTH];
      logic [sst_pkg::KEY_W-1:0]   gkeys  [sst_pkg::GLOBAL_DEPTH];
      logic [sst_pkg::VALUE_W-1:0] gvals  [sst_pkg::GLOBAL_DEPTH];
      int lcount;
      int gcount;
      int fail_count;
      sym_result_type owed_q[$];

      function new();
         lcount = 0;
         gcount = 0;
         fail_count = 0;
      endfunction

      task report(string what, logic [31:0] got, logic [31:0] want);
         $display("%0t: %s: got 0x%08h, want 0x%08h", $realtime, what, got, want);
         fail_count++;
      endtask

      // Top-down walk that stops at the first entry whose kind reaches stop_kind.
      function int find_local(logic [sst_pkg::KEY_W-1:0] key,
                              logic [sst_pkg::KIND_W-1:0] stop_kind);
         for (int i = lcount - 1; i >= 0; i--) begin
            if (lkinds[i] >= stop_kind)
               return -1;
            if (lkinds[i] == sst_pkg::KIND_VAR && lkeys[i] == key)
               return i;
         end
         return -1;
      endfunction

      function int find_global(logic [sst_pkg::KEY_W-1:0] key);
         for (int i = gcount - 1; i >= 0; i--)
            if (gkeys[i] == key)
               return i;
         return -1;
      endfunction

      function sst_pkg::status_type push_entry(logic [sst_pkg::KEY_W-1:0] key,
                                               logic [sst_pkg::VALUE_W-1:0] value,
                                               logic [sst_pkg::KIND_W-1:0] kind);
         if (lcount >= sst_pkg::LOCAL_DEPTH)
            return sst_pkg::ST_FULL;
         lkeys[lcount]  = key;
         lvals[lcount]  = value;
         lkinds[lcount] = kind;
         lcount++;
         return sst_pkg::ST_OK;
      endfunction

      function sst_pkg::status_type pop_through(logic [sst_pkg::KIND_W-1:0] kind);
         for (int i = lcount - 1; i >= 0; i--) begin
            if (lkinds[i] == kind) begin
               lcount = i;
               return sst_pkg::ST_OK;
            end
         end
         lcount = 0;
         return sst_pkg::ST_NO_MARKER;
      endfunction

      function sym_result_type apply_op(sst_pkg::mode_type mode,
                                        logic [sst_pkg::KEY_W-1:0] key,
                                        logic [sst_pkg::VALUE_W-1:0] value);
         sym_result_type res;
         int hit;
         res.value  = '0;
         res.status = sst_pkg::ST_OK;
         case (mode)
            sst_pkg::MODE_DECL_LOCAL: begin
               if (find_local(key, sst_pkg::KIND_BLOCK) >= 0)
                  res.status = sst_pkg::ST_DECLARED;
               else begin
                  res.status = push_entry(key, value, sst_pkg::KIND_VAR);
                  if (res.status == sst_pkg::ST_OK)
                     res.value = value;
               end
            end
            sst_pkg::MODE_DECL_GLOBAL: begin
               if (find_global(key) >= 0)
                  res.status = sst_pkg::ST_DECLARED;
               else if (gcount >= sst_pkg::GLOBAL_DEPTH)
                  res.status = sst_pkg::ST_FULL;
               else begin
                  gkeys[gcount] = key;
                  gvals[gcount] = value;
                  gcount++;
                  res.value = value;
               end
            end
            sst_pkg::MODE_SET, sst_pkg::MODE_GET: begin
               hit = find_local(key, sst_pkg::KIND_FUNC);
               if (hit >= 0) begin
                  if (mode == sst_pkg::MODE_SET)
                     lvals[hit] = value;
                  res.value = lvals[hit];
               end else begin
                  hit = find_global(key);
                  if (hit >= 0) begin
                     if (mode == sst_pkg::MODE_SET)
                        gvals[hit] = value;
                     res.value = gvals[hit];
                  end else
                     res.status = sst_pkg::ST_UNDECLARED;
               end
            end
            sst_pkg::MODE_ENTER_BLOCK:
               res.status = push_entry('0, '0, sst_pkg::KIND_BLOCK);
            sst_pkg::MODE_LEAVE_BLOCK:
               res.status = pop_through(sst_pkg::KIND_BLOCK);
            sst_pkg::MODE_ENTER_FUNC:
               res.status = push_entry('0, '0, sst_pkg::KIND_FUNC);
            default:
               res.status = pop_through(sst_pkg::KIND_FUNC);
         endcase
         return res;
      endfunction

      function void note_item(sst_pkg::mode_type mode, logic [sst_pkg::KEY_W-1:0] key,
                              logic [sst_pkg::VALUE_W-1:0] value);
         owed_q.push_back(apply_op(mode, key, value));
      endfunction

      task check_result(logic [sst_pkg::VALUE_W-1:0] value,
                        logic [sst_pkg::STAT_W-1:0] status);
         sym_result_type want;
         if (owed_q.size() == 0) begin
            report("result with nothing outstanding", value, status);
         end else begin
            want = owed_q.pop_front();
            if (value !== want.value)
               report("result_value", value, want.value);
            if (status !== want.status)
               report("status", status, want.status);
         end
      endtask

      task flush_owed();
         sym_result_type want;
         while (owed_q.size() != 0) begin
            want = owed_q.pop_front();
            report("result never arrived", 0, want.status);
         end
      endtask
   endclass

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [sst_pkg::REQ_TDATA_W-1:0] req_tdata = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [sst_pkg::RSP_TDATA_W-1:0] rsp_tdata;

   symtab_board board;
   int items_sent = 0;
   int gap_pct = 0;
   int stall_pct = 0;
   int stall_left = 0;
   logic [sst_pkg::KEY_W-1:0] key_pool [16];

   scoped_symbol_table u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #4 clock = ~clock;

   // Result side back-pressure comes in bursts.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(99) < stall_pct) begin
         stall_left = $urandom_range(13, 1) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_result(rsp_tdata[sst_pkg::VALUE_W-1:0],
                            rsp_tdata[sst_pkg::VALUE_W +: sst_pkg::STAT_W]);
   end

   // Must be called just after a rising edge; returns at the edge that takes the item.
   task send_item(sst_pkg::mode_type mode, logic [sst_pkg::KEY_W-1:0] key,
                  logic [sst_pkg::VALUE_W-1:0] value);
      logic [sst_pkg::REQ_TDATA_W-1:0] word;
      word = '0;
      word[sst_pkg::MODE_W-1:0] = mode;
      word[sst_pkg::MODE_W +: sst_pkg::KEY_W] = key;
      word[sst_pkg::MODE_W + sst_pkg::KEY_W +: sst_pkg::VALUE_W] = value;
      if ($urandom_range(99) < gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(13, 1)) @(posedge clock);
      end
      req_tdata  <= word;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      board.note_item(mode, key, value);
      items_sent++;
   endtask

   function logic [sst_pkg::VALUE_W-1:0] pick_value();
      case ($urandom_range(7))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   function logic [sst_pkg::KEY_W-1:0] pick_key();
      if ($urandom_range(15) == 0)
         return $urandom;
      return key_pool[$urandom_range(15)];
   endfunction

   task send_random_op();
      int r;
      sst_pkg::mode_type mode;
      r = $urandom_range(99);
      if (r < 22)
         mode = sst_pkg::MODE_DECL_LOCAL;
      else if (r < 26)
         mode = sst_pkg::MODE_DECL_GLOBAL;
      else if (r < 44)
         mode = sst_pkg::MODE_SET;
      else if (r < 66)
         mode = sst_pkg::MODE_GET;
      else if (r < 75)
         mode = sst_pkg::MODE_ENTER_BLOCK;
      else if (r < 83)
         mode = sst_pkg::MODE_LEAVE_BLOCK;
      else if (r < 91)
         mode = sst_pkg::MODE_ENTER_FUNC;
      else
         mode = sst_pkg::MODE_LEAVE_FUNC;
      send_item(mode, pick_key(), pick_value());
   endtask

   // Drives the local stack to its limit, then tries one more push of each kind and a get.
   task overflow_locals();
      int r;
      while (board.lcount < sst_pkg::LOCAL_DEPTH) begin
         r = $urandom_range(3);
         if (r == 0)
            send_item(sst_pkg::MODE_ENTER_BLOCK, $urandom, $urandom);
         else if (r == 1)
            send_item(sst_pkg::MODE_ENTER_FUNC, $urandom, $urandom);
         else
            send_item(sst_pkg::MODE_DECL_LOCAL, $urandom, pick_value());
      end
      send_item(sst_pkg::MODE_DECL_LOCAL, $urandom, pick_value());
      send_item(sst_pkg::MODE_ENTER_BLOCK, '0, '0);
      send_item(sst_pkg::MODE_ENTER_FUNC, '0, '0);
      send_item(sst_pkg::MODE_GET, pick_key(), '0);
   endtask

   task fill_globals();
      while (board.gcount < sst_pkg::GLOBAL_DEPTH)
         send_item(sst_pkg::MODE_DECL_GLOBAL, $urandom, pick_value());
      send_item(sst_pkg::MODE_DECL_GLOBAL, $urandom, pick_value());
      send_item(sst_pkg::MODE_DECL_GLOBAL, key_pool[0], pick_value());
      send_item(sst_pkg::MODE_DECL_GLOBAL, pick_key(), pick_value());
   endtask

   initial begin
      // Ends the run as failed if it has not finished in time.
      #12_000_000;
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      logic [sst_pkg::KEY_W-1:0] k_lo;
      logic [sst_pkg::KEY_W-1:0] k_hi;
      logic [sst_pkg::KEY_W-1:0] k_mid;
      int round;
      board = new();
      k_lo  = '0;
      k_hi  = '1;
      k_mid = 32'h5A5A_A5A5;
      key_pool[0] = k_lo;
      key_pool[1] = k_hi;
      for (int i = 2; i < 16; i++)
         key_pool[i] = $urandom;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed opening: empty table, shadowing, and both leaves crossing the other marker.
      send_item(sst_pkg::MODE_GET, k_lo, 32'd0);
      send_item(sst_pkg::MODE_LEAVE_BLOCK, k_hi, k_hi);
      send_item(sst_pkg::MODE_LEAVE_FUNC, k_lo, k_lo);
      send_item(sst_pkg::MODE_DECL_GLOBAL, k_lo, 32'h8000_0000);
      send_item(sst_pkg::MODE_DECL_GLOBAL, k_hi, 32'h7FFF_FFFF);
      send_item(sst_pkg::MODE_DECL_GLOBAL, k_lo, 32'd1);
      send_item(sst_pkg::MODE_GET, k_hi, 32'd0);
      send_item(sst_pkg::MODE_DECL_LOCAL, k_mid, 32'd11);
      send_item(sst_pkg::MODE_DECL_LOCAL, k_mid, 32'd22);
      send_item(sst_pkg::MODE_ENTER_BLOCK, k_mid, 32'd0);
      send_item(sst_pkg::MODE_DECL_LOCAL, k_mid, 32'd33);
      send_item(sst_pkg::MODE_SET, k_mid, 32'hFFFF_FFFB);
      send_item(sst_pkg::MODE_LEAVE_BLOCK, k_lo, 32'd0);
      send_item(sst_pkg::MODE_GET, k_mid, 32'd0);
      send_item(sst_pkg::MODE_ENTER_FUNC, k_lo, 32'd0);
      send_item(sst_pkg::MODE_GET, k_mid, 32'd0);
      send_item(sst_pkg::MODE_DECL_LOCAL, k_hi, 32'd44);
      send_item(sst_pkg::MODE_GET, k_hi, 32'd0);
      // Marker entries carry key zero but must never be hit.
      send_item(sst_pkg::MODE_GET, k_lo, 32'd0);
      send_item(sst_pkg::MODE_ENTER_BLOCK, k_lo, 32'd0);
      send_item(sst_pkg::MODE_LEAVE_FUNC, k_lo, 32'd0);
      send_item(sst_pkg::MODE_SET, k_hi, 32'h0000_1234);
      send_item(sst_pkg::MODE_ENTER_BLOCK, k_lo, 32'd0);
      send_item(sst_pkg::MODE_ENTER_FUNC, k_lo, 32'd0);
      send_item(sst_pkg::MODE_LEAVE_BLOCK, k_lo, 32'd0);
      send_item(sst_pkg::MODE_ENTER_FUNC, k_lo, 32'd0);
      send_item(sst_pkg::MODE_LEAVE_BLOCK, k_lo, 32'd0);

      for (round = 0; items_sent < 1950; round++) begin
         if (items_sent >= 1750) begin
            gap_pct   = 0;
            stall_pct = 0;
         end else if (round % 150 == 0) begin
            gap_pct   = ($urandom_range(2) == 0) ? 0 : $urandom_range(40, 5);
            stall_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(40, 5);
         end
         if (round == 900)
            fill_globals();
         else if (round % 300 == 150)
            overflow_locals();
         else
            send_random_op();
      end
      req_tvalid <= 1'b0;

      while (board.owed_q.size() != 0)
         @(posedge clock);
      repeat (140) @(posedge clock);
      board.flush_owed();
      if (board.fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/sst_pkg.sv
rtl/scoped_symbol_table.sv
rtl/sst_checker.sv
verif/testbench.sv
